// ===== hdl/psdl_pkg.sv =====
`timescale 1ns / 1ps

package psdl_pkg;

    // Field widths
    localparam int HEIGHT_W = 32;
    localparam int ELEN_W   = 16;
    localparam int EPOCH_W  = 18;
    localparam int SIZE_W   = 41;

    // Shared serial divider: dividend and divisor widths
    localparam int DIV_N   = 34;
    localparam int DIV_D   = 18;
    localparam int DIV_CNT_W = $clog2(DIV_N);

    // Epoch length handling
    localparam logic [ELEN_W-1:0] ELEN_RESET = 16'd60000;
    localparam logic [ELEN_W-1:0] ELEN_MIN   = 16'd30000;

    // Unit counts: base / unit as counts, growth / unit as shift amounts
    localparam logic [DIV_N-1:0] DS_BASE_UNITS = 34'd8388608;  // 2^30 / 128
    localparam logic [DIV_N-1:0] CA_BASE_UNITS = 34'd524288;   // 2^25 / 64
    localparam int DS_GROWTH_SH = 16;                          // 2^23 / 128
    localparam int CA_GROWTH_SH = 12;                          // 2^18 / 64
    localparam int DS_UNIT_SH   = 7;                           // 128-byte units
    localparam int CA_UNIT_SH   = 6;                           // 64-byte units

    // Selector codes
    localparam logic KIND_DATASET = 1'b0;
    localparam logic KIND_CACHE   = 1'b1;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                kind;
    } cmd_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [SIZE_W-1:0]  size_bytes;
    } res_t;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] dividend;
        logic [DIV_D-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_N-1:0] quotient;
        logic [DIV_D-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EPOCH,
        ST_ISSUE,
        ST_TEST
    } state_t;

endpackage

// ===== hdl/psdl_serdiv.sv =====
`timescale 1ns / 1ps

module psdl_serdiv (
    input  logic                clk,
    input  logic                rst_n,
    input  psdl_pkg::div_req_t  req,
    output psdl_pkg::div_rsp_t  rsp
);
    import psdl_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_N-1:0]     dq_reg, dq_next;
    logic [DIV_D-1:0]     rem_reg, rem_next;
    logic [DIV_D-1:0]     dsr_reg, dsr_next;
    logic [DIV_D:0]       partial;
    logic [DIV_D:0]       diff;

    // One quotient bit per cycle, restoring
    always_comb
    begin
        partial   = {rem_reg, dq_reg[DIV_N-1]};
        diff      = partial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (busy_reg)
        begin
            if (partial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[DIV_D-1:0];
                dq_next  = {dq_reg[DIV_N-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[DIV_D-1:0];
                dq_next  = {dq_reg[DIV_N-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_N - 1);
            dq_next   = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dq_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== hdl/prime_sized_dataset_length.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Signals                  | Transfer
// ----------+-----------+--------------------------+-------------------------------
// command   | in        | start, busy, cmd         | edge with start high, busy low
// result    | out       | done, result             | every cycle done is high
// config    | in        | cfg_we, cfg_wdata        | every edge with cfg_we high
//
// The epoch takes one pass of the shared bit-serial divider. Each trial
// divisor then costs a further pass (issue, quotient bits, test), so the time
// an item takes grows with the total trial divisors over all candidates tested.
// Reset sets epoch_length to 60000; there is no clearing pass.
// busy stays high until the result is out; done pulses one cycle, no stall.

module prime_sized_dataset_length (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  psdl_pkg::cmd_t               cmd,
    output logic                         done,
    output psdl_pkg::res_t               result,
    input  logic                         cfg_we,
    input  logic [psdl_pkg::ELEN_W-1:0]  cfg_wdata
);
    import psdl_pkg::*;

    state_t              state_reg, state_next;
    logic [ELEN_W-1:0]   elen_reg;
    logic [ELEN_W-1:0]   elen_eff;
    logic                kind_reg, kind_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [DIV_N-1:0]    cand_reg, cand_next;
    logic [DIV_D-1:0]    dvs_reg, dvs_next;
    logic                done_reg, done_next;
    res_t                res_reg, res_next;
    logic [DIV_N-1:0]    units0;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    psdl_serdiv u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Epoch length register, saturated at the low end when used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            elen_reg <= ELEN_RESET;
        else if (cfg_we)
            elen_reg <= cfg_wdata;
    end

    assign elen_eff = (elen_reg < ELEN_MIN) ? ELEN_MIN : elen_reg;

    // First candidate unit count from the fresh epoch
    always_comb
    begin
        if (kind_reg == KIND_CACHE)
            units0 = (DIV_N'(div_rsp.quotient[EPOCH_W-1:0]) << CA_GROWTH_SH)
                     + CA_BASE_UNITS - 1'b1;
        else
            units0 = (DIV_N'(div_rsp.quotient[EPOCH_W-1:0]) << DS_GROWTH_SH)
                     + DS_BASE_UNITS - 1'b1;
    end

    // Sequencer: epoch division, then trial division per candidate
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        epoch_next = epoch_reg;
        cand_next  = cand_reg;
        dvs_next   = dvs_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_N'(cmd.height);
        div_req.divisor  = DIV_D'(elen_eff);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next     = cmd.kind;
                    div_req.start = 1'b1;
                    state_next    = ST_EPOCH;
                end
            end
            ST_EPOCH:
            begin
                if (div_rsp.done)
                begin
                    epoch_next = div_rsp.quotient[EPOCH_W-1:0];
                    cand_next  = units0;
                    dvs_next   = DIV_D'(2);
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = cand_reg;
                div_req.divisor  = dvs_reg;
                state_next       = ST_TEST;
            end
            ST_TEST:
            begin
                if (div_rsp.done)
                begin
                    if (DIV_N'(dvs_reg) > div_rsp.quotient)
                    begin
                        // no divisor up to the square root: prime
                        res_next.epoch = epoch_reg;
                        if (kind_reg == KIND_CACHE)
                            res_next.size_bytes = SIZE_W'(cand_reg) << CA_UNIT_SH;
                        else
                            res_next.size_bytes = SIZE_W'(cand_reg) << DS_UNIT_SH;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (div_rsp.remainder == '0)
                    begin
                        // composite: step down one unit
                        cand_next  = cand_reg - 1'b1;
                        dvs_next   = DIV_D'(2);
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        // after 2 only odd divisors matter
                        if (dvs_reg == DIV_D'(2))
                            dvs_next = DIV_D'(3);
                        else
                            dvs_next = dvs_reg + DIV_D'(2);
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        epoch_reg <= epoch_next;
        cand_reg  <= cand_next;
        dvs_reg   <= dvs_next;
        res_reg   <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== bench/prime_sized_dataset_length_tb.sv =====
`timescale 1ns / 1ps

module prime_sized_dataset_length_tb;
    import psdl_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 5;
    // The slowest item (dataset size near the top of the epoch range) runs longest
    // with no transfer; the limit is set to cover it.
    localparam int WATCHDOG_CYCLES = 16_000_000;
    localparam int MAX_REPORTS     = 10;
    localparam int PHASE_ITEMS     = 20;
    localparam int END_SETTLE      = 20;

    // Sizing rules
    localparam longint unsigned DATASET_BASE_BYTES   = 64'd1 << 30;
    localparam longint unsigned DATASET_GROWTH_BYTES = 64'd1 << 23;
    localparam longint unsigned DATASET_UNIT_BYTES   = 64'd128;
    localparam longint unsigned CACHE_BASE_BYTES     = 64'd1 << 25;
    localparam longint unsigned CACHE_GROWTH_BYTES   = 64'd1 << 18;
    localparam longint unsigned CACHE_UNIT_BYTES     = 64'd64;
    localparam logic [ELEN_W-1:0] EPOCH_LEN_AT_RESET = 16'd60000;
    localparam logic [ELEN_W-1:0] EPOCH_LEN_FLOOR    = 16'd30000;
    localparam logic [ELEN_W-1:0] EPOCH_LEN_CEIL     = 16'd65535;
    localparam logic [HEIGHT_W-1:0] HEIGHT_TOP       = 32'hFFFF_FFFF;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    cmd_t               cmd;
    logic               done;
    res_t               result;
    logic               cfg_we;
    logic [ELEN_W-1:0]  cfg_wdata;

    // Epoch length as the block should hold it
    logic [ELEN_W-1:0]  epoch_len_shadow;
    res_t               size_expect_q[$];
    int                 mismatch_count;
    int                 results_seen;
    int                 dataset_cmds;
    int                 cache_cmds;
    int                 epoch_len_writes;
    int                 stall_cycles;

    prime_sized_dataset_length u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Trial division on the unit count
    function automatic bit unit_count_prime(input longint unsigned n);
        longint unsigned d;
        if (n < 2)
            return 1'b0;
        for (d = 2; d <= n / d; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Epoch and prime-sized byte count for one command
    function automatic res_t predict_sizes(input cmd_t c, input logic [ELEN_W-1:0] len_reg);
        longint unsigned eff_len;
        longint unsigned epoch_val;
        longint unsigned base_bytes;
        longint unsigned growth_bytes;
        longint unsigned unit_bytes;
        longint unsigned units;
        longint unsigned total_bytes;
        res_t r;
        // small register values act as the floor
        eff_len = (len_reg < EPOCH_LEN_FLOOR) ? EPOCH_LEN_FLOOR : len_reg;
        epoch_val = c.height / eff_len;
        if (c.kind == KIND_DATASET)
        begin
            base_bytes   = DATASET_BASE_BYTES;
            growth_bytes = DATASET_GROWTH_BYTES;
            unit_bytes   = DATASET_UNIT_BYTES;
        end
        else
        begin
            base_bytes   = CACHE_BASE_BYTES;
            growth_bytes = CACHE_GROWTH_BYTES;
            unit_bytes   = CACHE_UNIT_BYTES;
        end
        units = (base_bytes + growth_bytes * epoch_val) / unit_bytes - 1;
        while (units >= 2 && !unit_count_prime(units))
            units--;
        total_bytes  = units * unit_bytes;
        r.epoch      = epoch_val[EPOCH_W-1:0];
        r.size_bytes = total_bytes[SIZE_W-1:0];
        return r;
    endfunction

    // Mostly short gaps, about a third none, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // One command transfer; start is left high so a zero gap keeps it asserted
    task automatic send_cmd(input logic [HEIGHT_W-1:0] height, input logic kind_sel);
        int   gap;
        cmd_t c;
        gap = pick_gap();
        c.height = height;
        c.kind   = kind_sel;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        size_expect_q.push_back(predict_sizes(c, epoch_len_shadow));
        if (kind_sel == KIND_DATASET)
            dataset_cmds++;
        else
            cache_cmds++;
    endtask

    // Wait until every result is in and the block is idle
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (size_expect_q.size() != 0 || busy);
    endtask

    task automatic write_epoch_len(input logic [ELEN_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        epoch_len_shadow = value;
        epoch_len_writes++;
    endtask

    task automatic apply_reset();
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cmd       <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        epoch_len_shadow = EPOCH_LEN_AT_RESET;
    endtask

    // Default epoch length, both kinds, an epoch boundary, the top height
    task automatic test_reset_defaults();
        send_cmd(32'd0, KIND_DATASET);
        send_cmd(32'd0, KIND_CACHE);
        send_cmd(32'd59999, KIND_CACHE);
        send_cmd(32'd60000, KIND_CACHE);
        send_cmd(32'd60000, KIND_DATASET);
        send_cmd(HEIGHT_TOP, KIND_CACHE);
    endtask

    // Saturation below the floor, both ends of the range, boundaries around them
    task automatic test_epoch_len_extremes();
        write_epoch_len(16'd0);
        send_cmd(32'd29999, KIND_CACHE);
        send_cmd(32'd30000, KIND_CACHE);
        send_cmd(HEIGHT_TOP, KIND_CACHE);

        write_epoch_len(EPOCH_LEN_FLOOR - 16'd1);
        send_cmd(32'd30000, KIND_DATASET);
        send_cmd(32'd59999, KIND_CACHE);

        write_epoch_len(EPOCH_LEN_FLOOR);
        send_cmd(32'd90000, KIND_CACHE);
        send_cmd(32'd89999, KIND_CACHE);

        write_epoch_len(EPOCH_LEN_FLOOR + 16'd1);
        send_cmd(32'd30001, KIND_CACHE);
        send_cmd(32'd30000, KIND_CACHE);

        // one dataset item at the largest size it is run with
        write_epoch_len(EPOCH_LEN_CEIL);
        send_cmd(HEIGHT_TOP, KIND_DATASET);
        send_cmd(32'd65535, KIND_CACHE);
        send_cmd(32'd65534, KIND_CACHE);
        send_cmd(32'd131070, KIND_DATASET);
    endtask

    // Random heights; kept to low epochs mostly so the trial division stays short
    task automatic test_random_heights();
        logic [ELEN_W-1:0]   len_pick;
        logic [HEIGHT_W-1:0] height;
        logic                kind_sel;
        int unsigned         eff_len;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: len_pick = ELEN_W'($urandom_range(EPOCH_LEN_FLOOR, EPOCH_LEN_CEIL));
                1: len_pick = ELEN_W'($urandom_range(0, EPOCH_LEN_FLOOR - 1));
                2: len_pick = EPOCH_LEN_FLOOR;
                default: len_pick = EPOCH_LEN_CEIL;
            endcase
            write_epoch_len(len_pick);
            eff_len = (len_pick < EPOCH_LEN_FLOOR) ? EPOCH_LEN_FLOOR : len_pick;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                kind_sel = ($urandom_range(0, 99) < 85) ? KIND_CACHE : KIND_DATASET;
                if (kind_sel == KIND_DATASET)
                    height = $urandom_range(0, 6 * eff_len);
                else if ($urandom_range(0, 99) < 3)
                    height = $urandom();
                else
                    height = $urandom_range(0, 40 * eff_len);
                send_cmd(height, kind_sel);
            end
        end
    endtask

    // Result checker: one transfer per cycle with done high
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            if (size_expect_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: unexpected result epoch=%0d size_bytes=%0d",
                             result.epoch, result.size_bytes);
            end
            else
            begin
                want = size_expect_q.pop_front();
                results_seen++;
                if (result.epoch !== want.epoch || result.size_bytes !== want.size_bytes)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("ERROR: result %0d: epoch exp %0d got %0d, size exp %0d got %0d",
                                 results_seen, want.epoch, result.epoch,
                                 want.size_bytes, result.size_bytes);
                end
            end
        end
    end

    // Watchdog on cycles with no transfer in either direction
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_CYCLES)
        begin
            $display("ERROR: no transfer for %0d cycles", WATCHDOG_CYCLES);
            $display("Test completed with failures");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        mismatch_count   = 0;
        results_seen     = 0;
        dataset_cmds     = 0;
        cache_cmds       = 0;
        epoch_len_writes = 0;
        stall_cycles     = 0;

        apply_reset();
        test_reset_defaults();
        test_epoch_len_extremes();
        test_random_heights();

        drain_results();
        repeat (END_SETTLE) @(posedge clk);

        $display("Sent %0d commands (%0d dataset, %0d cache) across %0d epoch length settings",
                 dataset_cmds + cache_cmds, dataset_cmds, cache_cmds, epoch_len_writes + 1);
        $display("Checked %0d results, %0d mismatches", results_seen, mismatch_count);
        if (mismatch_count == 0 && size_expect_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
